// ===== rtl/lyr3_pkg.sv =====
// Shared types, constants and helpers for the Lyrics3v2 field extractor.
package lyr3_pkg;

    localparam int unsigned DEFAULT_MAX_TAG_BYTES = 1048576;

    localparam int DATA_W    = 8;
    localparam int TAG_LEN_W = 21;
    localparam int SIZE_W    = 17;
    localparam int FTAG_W    = 24;
    localparam int HIDX_W    = 4;
    localparam int DIDX_W    = 3;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 2;

    localparam logic [HIDX_W-1:0] HEADER_LEN   = HIDX_W'(11);
    localparam logic [DIDX_W-1:0] FID_CHARS    = DIDX_W'(3);
    localparam logic [DIDX_W-1:0] SIZE_CHARS   = DIDX_W'(5);
    localparam int unsigned       FIELD_HDR_MIN = 8;

    localparam logic [APB_AW-1:0] REG_PARSE_ENABLE = APB_AW'(0);

    localparam logic [FTAG_W-1:0] FID_ETT = 24'h455454;
    localparam logic [FTAG_W-1:0] FID_EAR = 24'h454152;
    localparam logic [FTAG_W-1:0] FID_EAL = 24'h45414C;

    localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [DATA_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [DATA_W-1:0] CH_NINE  = 8'h39;

    localparam logic [1:0] KIND_TITLE  = 2'd0;
    localparam logic [1:0] KIND_ARTIST = 2'd1;
    localparam logic [1:0] KIND_ALBUM  = 2'd2;
    localparam logic [1:0] KIND_SKIP   = 2'd3;

    localparam logic [1:0] STAT_PENDING  = 2'd0;
    localparam logic [1:0] STAT_PARSING  = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;
    localparam logic [1:0] STAT_FINISHED = 2'd3;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_HEADER   = 7'b0000010,
        PH_FID      = 7'b0000100,
        PH_SIZE     = 7'b0001000,
        PH_PAYLOAD  = 7'b0010000,
        PH_REJECTED = 7'b0100000,
        PH_FINISHED = 7'b1000000
    } phase_t;

    typedef enum logic [3:0] {
        NUM_SPACE = 4'b0001,
        NUM_POS   = 4'b0010,
        NUM_NEG   = 4'b0100,
        NUM_DONE  = 4'b1000
    } num_state_t;

    typedef struct packed {
        logic [DATA_W-1:0]    data_byte;
        logic                 start_of_tag;
        logic [TAG_LEN_W-1:0] tag_length;
    } lyr3_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] char_out;
        logic              char_valid;
        logic [1:0]        field_code;
        logic              field_last;
        logic [1:0]        tag_status;
    } lyr3_out_t;

    // "LYRICSBEGIN"
    function automatic logic [DATA_W-1:0] header_char(input logic [HIDX_W-1:0] idx);
        logic [DATA_W-1:0] c;
        unique case (idx)
            4'd0:    c = 8'h4C;
            4'd1:    c = 8'h59;
            4'd2:    c = 8'h52;
            4'd3:    c = 8'h49;
            4'd4:    c = 8'h43;
            4'd5:    c = 8'h53;
            4'd6:    c = 8'h42;
            4'd7:    c = 8'h45;
            4'd8:    c = 8'h47;
            4'd9:    c = 8'h49;
            4'd10:   c = 8'h4E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [DATA_W-1:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// ===== rtl/lyrics3v2_field_extractor_core.sv =====
// Lyrics3v2 tag parser top level: byte-stream field extractor with APB control.
//
// Takes one tag byte per cycle and returns exactly one result transaction per
// byte: a title, artist or album character with its field code and last flag,
// plus the tag status after that byte. Throughput is one byte per cycle when
// the output is not stalled; each byte passes through a single stage of parser
// logic between the input handshake and the result register, so a result is
// registered in the cycle after its byte is taken. The input stays ready while
// the result register is empty or being drained. parse_enable sits at APB
// address 0 and should only be written while no transaction is in flight.
module lyrics3v2_field_extractor_core
    import lyr3_pkg::*;
#(
    parameter int unsigned MAX_TAG_BYTES = DEFAULT_MAX_TAG_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  lyr3_in_t          s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output lyr3_out_t         m_data,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int BL_FULL = $clog2(MAX_TAG_BYTES + 1);
    localparam int BL_W    = (BL_FULL < TAG_LEN_W) ? BL_FULL : TAG_LEN_W;
    localparam int CMP_W   = (BL_W > SIZE_W) ? BL_W : SIZE_W;

    logic                 parse_enable_reg;
    phase_t               phase_reg,        phase_next;
    logic [HIDX_W-1:0]    header_index_reg, header_index_next;
    logic [BL_W-1:0]      bytes_left_reg,   bytes_left_next;
    logic [FTAG_W-1:0]    field_tag_reg,    field_tag_next;
    logic [SIZE_W-1:0]    size_value_reg,   size_value_next;
    logic [DIDX_W-1:0]    digit_index_reg,  digit_index_next;
    num_state_t           num_state_reg,    num_state_next;
    logic [SIZE_W-1:0]    payload_left_reg, payload_left_next;
    logic [1:0]           field_kind_reg,   field_kind_next;
    logic                 size_over_reg,    size_over_next;

    logic                 m_valid_reg;
    lyr3_out_t            m_data_reg,       m_data_next;

    logic                 in_accept;
    logic [BL_W-1:0]      len_clamped;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign pready = 1'b1;
    assign prdata = {{(APB_DW-1){1'b0}}, parse_enable_reg};

    assign len_clamped = ({11'd0, s_data.tag_length} > 32'(MAX_TAG_BYTES))
                       ? BL_W'(MAX_TAG_BYTES) : BL_W'(s_data.tag_length);

    always_comb begin
        logic [DATA_W-1:0] b;
        logic              digit;
        logic [3:0]        dval;
        logic [BL_W-1:0]   bl_dec;

        b     = s_data.data_byte;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        dval  = b[3:0];

        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        bytes_left_next   = bytes_left_reg;
        field_tag_next    = field_tag_reg;
        size_value_next   = size_value_reg;
        digit_index_next  = digit_index_reg;
        num_state_next    = num_state_reg;
        payload_left_next = payload_left_reg;
        field_kind_next   = field_kind_reg;
        size_over_next    = size_over_reg;

        m_data_next = '0;

        if (s_data.start_of_tag) begin
            bytes_left_next   = len_clamped;
            header_index_next = '0;
            field_tag_next    = '0;
            size_value_next   = '0;
            digit_index_next  = '0;
            num_state_next    = NUM_SPACE;
            payload_left_next = '0;
            field_kind_next   = KIND_SKIP;
            size_over_next    = 1'b0;
            phase_next = (!parse_enable_reg || (len_clamped < BL_W'(HEADER_LEN)))
                       ? PH_REJECTED : PH_HEADER;
        end

        bl_dec = (bytes_left_next != '0) ? bytes_left_next - BL_W'(1) : bytes_left_next;

        unique case (phase_next)
            PH_HEADER: begin
                if ((header_index_next >= HEADER_LEN) ||
                    (b != header_char(header_index_next))) begin
                    phase_next = PH_REJECTED;
                end else begin
                    bytes_left_next   = bl_dec;
                    header_index_next = header_index_next + HIDX_W'(1);
                    if (header_index_next == HEADER_LEN) begin
                        phase_next = (bytes_left_next > BL_W'(FIELD_HDR_MIN))
                                   ? PH_FID : PH_FINISHED;
                        digit_index_next = '0;
                        field_tag_next   = '0;
                    end
                end
            end
            PH_FID: begin
                field_tag_next   = {field_tag_next[FTAG_W-DATA_W-1:0], b};
                bytes_left_next  = bl_dec;
                digit_index_next = digit_index_next + DIDX_W'(1);
                if (digit_index_next >= FID_CHARS) begin
                    phase_next       = PH_SIZE;
                    digit_index_next = '0;
                    num_state_next   = NUM_SPACE;
                    size_value_next  = '0;
                    size_over_next   = 1'b0;
                end
            end
            PH_SIZE: begin
                unique case (num_state_next)
                    NUM_SPACE: begin
                        priority if (is_space(b)) begin
                            num_state_next = NUM_SPACE;
                        end else if (b == CH_PLUS) begin
                            num_state_next = NUM_POS;
                        end else if (b == CH_MINUS) begin
                            num_state_next = NUM_NEG;
                        end else if (digit) begin
                            num_state_next  = NUM_POS;
                            size_value_next = SIZE_W'(dval);
                        end else begin
                            num_state_next = NUM_DONE;
                        end
                    end
                    NUM_POS, NUM_NEG: begin
                        if (digit) begin
                            size_value_next = (size_value_next << 3)
                                            + (size_value_next << 1) + SIZE_W'(dval);
                        end else begin
                            if ((num_state_next == NUM_NEG) && (size_value_next != '0))
                                size_over_next = 1'b1;
                            num_state_next = NUM_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
                bytes_left_next  = bl_dec;
                digit_index_next = digit_index_next + DIDX_W'(1);
                if (digit_index_next >= SIZE_CHARS) begin
                    if ((num_state_next == NUM_NEG) && (size_value_next != '0))
                        size_over_next = 1'b1;
                    priority if (field_tag_next == FID_ETT) field_kind_next = KIND_TITLE;
                    else if (field_tag_next == FID_EAR) field_kind_next = KIND_ARTIST;
                    else if (field_tag_next == FID_EAL) field_kind_next = KIND_ALBUM;
                    else field_kind_next = KIND_SKIP;
                    priority if (size_over_next ||
                                 (CMP_W'(size_value_next) > CMP_W'(bytes_left_next))) begin
                        phase_next = PH_FINISHED;
                    end else if (size_value_next == '0) begin
                        phase_next = (bytes_left_next > BL_W'(FIELD_HDR_MIN))
                                   ? PH_FID : PH_FINISHED;
                        digit_index_next = '0;
                        field_tag_next   = '0;
                    end else begin
                        payload_left_next = size_value_next;
                        phase_next        = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                bytes_left_next = bl_dec;
                if (field_kind_next != KIND_SKIP) begin
                    m_data_next.char_out   = b;
                    m_data_next.char_valid = 1'b1;
                    m_data_next.field_code = field_kind_next;
                    m_data_next.field_last = (payload_left_next <= SIZE_W'(1));
                end
                if (payload_left_next != '0)
                    payload_left_next = payload_left_next - SIZE_W'(1);
                if (payload_left_next == '0) begin
                    phase_next = (bytes_left_next > BL_W'(FIELD_HDR_MIN))
                               ? PH_FID : PH_FINISHED;
                    digit_index_next = '0;
                    field_tag_next   = '0;
                end
            end
            default: begin
            end
        endcase

        unique case (phase_next)
            PH_FID, PH_SIZE, PH_PAYLOAD: m_data_next.tag_status = STAT_PARSING;
            PH_REJECTED:                 m_data_next.tag_status = STAT_REJECTED;
            PH_FINISHED:                 m_data_next.tag_status = STAT_FINISHED;
            default:                     m_data_next.tag_status = STAT_PENDING;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_enable_reg <= 1'b1;
        end else if (psel && penable && pwrite && (paddr == REG_PARSE_ENABLE)) begin
            parse_enable_reg <= pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            header_index_reg <= '0;
            bytes_left_reg   <= '0;
            field_tag_reg    <= '0;
            size_value_reg   <= '0;
            digit_index_reg  <= '0;
            num_state_reg    <= NUM_SPACE;
            payload_left_reg <= '0;
            field_kind_reg   <= KIND_SKIP;
            size_over_reg    <= 1'b0;
        end else if (in_accept) begin
            phase_reg        <= phase_next;
            header_index_reg <= header_index_next;
            bytes_left_reg   <= bytes_left_next;
            field_tag_reg    <= field_tag_next;
            size_value_reg   <= size_value_next;
            digit_index_reg  <= digit_index_next;
            num_state_reg    <= num_state_next;
            payload_left_reg <= payload_left_next;
            field_kind_reg   <= field_kind_next;
            size_over_reg    <= size_over_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
